// File: sv/mbr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbr_pkg
// Shared types, field widths and codes of the msb-first bit reader.
// ----------------------------------------------------------------------------
package mbr_pkg;

    localparam int FUNC_W   = 3;
    localparam int NBITS_W  = 6;
    localparam int BYTE_W   = 8;
    localparam int BITS_W   = 32;
    localparam int STATUS_W = 2;
    localparam int ALIGN_W  = 3;
    localparam int REMAIN_W = 12;
    localparam int POS_W    = 32;

    localparam int DEF_FIFO_DEPTH    = 256;
    localparam int DEF_MAX_READ_BITS = 32;

    // command queue between front and back, power of two
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_GET   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEEK  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_ALIGN = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_GET,
        OP_PEEK,
        OP_ALIGN,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [NBITS_W-1:0] num_bits;
        logic [BYTE_W-1:0]  data;
    } t_cmd;

endpackage
`default_nettype wire

// File: sv/msb_first_bit_reader.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msb_first_bit_reader
// MSB-first bit reader over a byte FIFO with a bit window for field reads.
// ----------------------------------------------------------------------------
// Input words (i_valid/o_ready) carry a function, a bit count and a byte:
// load, get, peek, align or clear. Each input word yields one result word
// (o_valid/i_ready) with the bits read, a status, the align count, the
// unread bit total and the running bit position.
// An accepted word passes the command queue, then the output register.
// Loads, aligns, clears and ignored words run at one word per cycle unless
// the receiver stalls. A get or peek of n bits runs at once when the bit
// window already holds n bits; the window takes one byte per cycle while it
// has room from the byte store's registered read port, so back-to-back reads
// sustain about 8 bits per cycle, plus a store read when the window is empty.
// A short command queue parts the input side from the execution side and an
// output register holds a result while the receiver stalls; the block keeps
// taking words until the queue fills.
// Synchronous reset empties the queue, the store and the window and zeroes
// the bit position; store contents are left as they are.
// ----------------------------------------------------------------------------
module msb_first_bit_reader #(
    parameter int FIFO_DEPTH    = mbr_pkg::DEF_FIFO_DEPTH,
    parameter int MAX_READ_BITS = mbr_pkg::DEF_MAX_READ_BITS
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire [mbr_pkg::FUNC_W-1:0]     i_func,
    input  wire [mbr_pkg::NBITS_W-1:0]    i_num_bits,
    input  wire [mbr_pkg::BYTE_W-1:0]     i_load_byte,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic [mbr_pkg::BITS_W-1:0]    o_bits_out,
    output logic [mbr_pkg::STATUS_W-1:0]  o_status,
    output logic [mbr_pkg::ALIGN_W-1:0]   o_aligned_count,
    output logic [mbr_pkg::REMAIN_W-1:0]  o_remain_bits,
    output logic [mbr_pkg::POS_W-1:0]     o_bit_position
);

    logic          cmd_vld;
    logic          cmd_rdy;
    mbr_pkg::t_cmd cmd;

    mbr_front #(
        .MAX_READ_BITS (MAX_READ_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_num_bits  (i_num_bits),
        .i_load_byte (i_load_byte),
        .o_cmd_vld   (cmd_vld),
        .i_cmd_rdy   (cmd_rdy),
        .o_cmd       (cmd)
    );

    mbr_back #(
        .FIFO_DEPTH    (FIFO_DEPTH),
        .MAX_READ_BITS (MAX_READ_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_vld       (cmd_vld),
        .o_cmd_rdy       (cmd_rdy),
        .i_cmd           (cmd),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_bits_out      (o_bits_out),
        .o_status        (o_status),
        .o_aligned_count (o_aligned_count),
        .o_remain_bits   (o_remain_bits),
        .o_bit_position  (o_bit_position)
    );

endmodule
`default_nettype wire

// File: sv/mbr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbr_front
// Accepts input words, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
module mbr_front #(
    parameter int MAX_READ_BITS = mbr_pkg::DEF_MAX_READ_BITS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire [mbr_pkg::FUNC_W-1:0]    i_func,
    input  wire [mbr_pkg::NBITS_W-1:0]   i_num_bits,
    input  wire [mbr_pkg::BYTE_W-1:0]    i_load_byte,
    output logic                         o_cmd_vld,
    input  wire                          i_cmd_rdy,
    output mbr_pkg::t_cmd                o_cmd
);

    localparam int CNT_W = $clog2(mbr_pkg::Q_DEPTH + 1);

    mbr_pkg::t_cmd            r_q [mbr_pkg::Q_DEPTH];
    logic [mbr_pkg::Q_AW-1:0] r_wp, n_wp;
    logic [mbr_pkg::Q_AW-1:0] r_rp, n_rp;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    mbr_pkg::t_cmd            dec;
    logic                     n_ok;
    logic                     push;
    logic                     pop;

    // get or peek with a count of zero or above the limit does nothing
    assign n_ok = (i_num_bits != '0) &&
                  (i_num_bits <= mbr_pkg::NBITS_W'(MAX_READ_BITS));

    always_comb begin
        dec.num_bits = i_num_bits;
        dec.data     = i_load_byte;
        case (i_func)
            mbr_pkg::FUNC_LOAD:  dec.op = mbr_pkg::OP_LOAD;
            mbr_pkg::FUNC_GET:   dec.op = n_ok ? mbr_pkg::OP_GET : mbr_pkg::OP_NOP;
            mbr_pkg::FUNC_PEEK:  dec.op = n_ok ? mbr_pkg::OP_PEEK : mbr_pkg::OP_NOP;
            mbr_pkg::FUNC_ALIGN: dec.op = mbr_pkg::OP_ALIGN;
            mbr_pkg::FUNC_CLEAR: dec.op = mbr_pkg::OP_CLEAR;
            default:             dec.op = mbr_pkg::OP_NOP;
        endcase
    end

    assign o_ready   = (r_cnt != CNT_W'(mbr_pkg::Q_DEPTH));
    assign o_cmd_vld = (r_cnt != '0);
    assign o_cmd     = r_q[r_rp];
    assign push      = i_valid && o_ready;
    assign pop       = i_cmd_rdy && o_cmd_vld;

    always_comb begin
        n_wp  = push ? r_wp + mbr_pkg::Q_AW'(1) : r_wp;
        n_rp  = pop ? r_rp + mbr_pkg::Q_AW'(1) : r_rp;
        n_cnt = r_cnt + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

endmodule
`default_nettype wire

// File: sv/mbr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbr_back
// Byte store, bit window with byte refill, command execution, result register.
// ----------------------------------------------------------------------------
module mbr_back #(
    parameter int FIFO_DEPTH    = mbr_pkg::DEF_FIFO_DEPTH,
    parameter int MAX_READ_BITS = mbr_pkg::DEF_MAX_READ_BITS
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cmd_vld,
    output logic                          o_cmd_rdy,
    input  mbr_pkg::t_cmd                 i_cmd,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic [mbr_pkg::BITS_W-1:0]    o_bits_out,
    output logic [mbr_pkg::STATUS_W-1:0]  o_status,
    output logic [mbr_pkg::ALIGN_W-1:0]   o_aligned_count,
    output logic [mbr_pkg::REMAIN_W-1:0]  o_remain_bits,
    output logic [mbr_pkg::POS_W-1:0]     o_bit_position
);

    localparam int WIN    = MAX_READ_BITS + 16;
    localparam int WCNT_W = $clog2(WIN + 1);
    localparam int AW     = $clog2(FIFO_DEPTH);
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int TOT_W  = $clog2(8 * FIFO_DEPTH + 8);
    localparam int NW     = mbr_pkg::NBITS_W;

    logic [7:0]               r_mem [FIFO_DEPTH];
    logic [7:0]               r_rd_data;
    logic                     r_rd_vld, n_rd_vld;
    logic [AW-1:0]            r_wptr, n_wptr;
    logic [AW-1:0]            r_rptr, n_rptr;
    logic [CNT_W-1:0]         r_mcnt, n_mcnt;
    logic [WIN-1:0]           r_win, n_win;
    logic [WCNT_W-1:0]        r_wcnt, n_wcnt;
    logic [TOT_W-1:0]         r_total, n_total;
    logic [mbr_pkg::POS_W-1:0] r_pos, n_pos;

    logic                     r_o_vld;
    logic [mbr_pkg::BITS_W-1:0]   r_bits, n_bits;
    logic [mbr_pkg::STATUS_W-1:0] r_status, n_status;
    logic [mbr_pkg::ALIGN_W-1:0]  r_aligned, n_aligned;
    logic [mbr_pkg::REMAIN_W-1:0] r_remain;

    logic              out_free;
    logic              get_like;
    logic              have;
    logic              drained;
    logic              exec;
    logic              is_clear;
    logic              full;
    logic              load_ok;
    logic              issue;
    logic [NW-1:0]     nb;
    logic [NW-1:0]     wcnt6;
    logic [NW-1:0]     sh_amt;
    logic [NW-1:0]     fill_amt;
    logic [63:0]       win64;
    logic [63:0]       shifted;
    logic [32:0]       m_n;
    logic [32:0]       m_w;
    logic [31:0]       low;
    logic [WCNT_W-1:0] wcnt_c;
    logic [WCNT_W:0]   proj;
    logic [2:0]        pleft;

    assign nb       = i_cmd.num_bits;
    assign wcnt6    = NW'(r_wcnt);
    assign out_free = !r_o_vld || i_ready;
    assign get_like = i_cmd.op inside {mbr_pkg::OP_GET, mbr_pkg::OP_PEEK};
    assign have     = (wcnt6 >= nb);
    assign drained  = (r_mcnt == '0) && !r_rd_vld;
    // a read waits until the window holds enough bits or the store has run dry
    assign exec      = i_cmd_vld && out_free && (!get_like || have || drained);
    assign o_cmd_rdy = exec;
    assign is_clear  = exec && (i_cmd.op == mbr_pkg::OP_CLEAR);
    assign full      = ((r_total >> 3) >= TOT_W'(FIFO_DEPTH));
    assign load_ok   = exec && (i_cmd.op == mbr_pkg::OP_LOAD) && !full;
    assign pleft     = r_wcnt[2:0];

    // conservative space check: the byte in flight and the byte issued now must both fit
    assign proj  = (WCNT_W + 1)'(r_wcnt) + (r_rd_vld ? (WCNT_W + 1)'(8) : '0);
    assign issue = (r_mcnt != '0) && (proj <= (WCNT_W + 1)'(WIN - 8)) && !is_clear;

    // bit extraction
    always_comb begin
        win64    = 64'(r_win);
        sh_amt   = wcnt6 - nb;
        fill_amt = nb - wcnt6;
        shifted  = win64 >> sh_amt;
        m_n      = {33{1'b1}} << nb;
        m_w      = {33{1'b1}} << wcnt6;
        low      = win64[31:0] & ~m_w[31:0];
    end

    always_comb begin
        n_bits    = '0;
        n_status  = mbr_pkg::ST_OK;
        n_aligned = '0;
        n_total   = r_total;
        n_pos     = r_pos;
        wcnt_c    = r_wcnt;
        n_wptr    = r_wptr;
        n_rptr    = r_rptr;
        n_mcnt    = r_mcnt;
        n_win     = r_win;
        n_rd_vld  = issue;

        if (exec) begin
            case (i_cmd.op)
                mbr_pkg::OP_LOAD: begin
                    if (full) begin
                        n_status = mbr_pkg::ST_FULL;
                    end else begin
                        n_total = r_total + TOT_W'(8);
                    end
                end
                mbr_pkg::OP_GET, mbr_pkg::OP_PEEK: begin
                    if (have) begin
                        n_bits = shifted[31:0] & ~m_n[31:0];
                    end else begin
                        n_bits   = low << fill_amt;
                        n_status = mbr_pkg::ST_SHORT;
                    end
                    if (i_cmd.op == mbr_pkg::OP_GET) begin
                        n_pos = r_pos + mbr_pkg::POS_W'(nb);
                        if (have) begin
                            wcnt_c  = r_wcnt - WCNT_W'(nb);
                            n_total = r_total - TOT_W'(nb);
                        end else begin
                            wcnt_c  = '0;
                            n_total = '0;
                        end
                    end
                end
                mbr_pkg::OP_ALIGN: begin
                    n_aligned = pleft;
                    wcnt_c    = r_wcnt - WCNT_W'(pleft);
                    n_total   = r_total - TOT_W'(pleft);
                    n_pos     = r_pos + mbr_pkg::POS_W'(pleft);
                end
                mbr_pkg::OP_CLEAR: begin
                    wcnt_c  = '0;
                    n_total = '0;
                    n_pos   = '0;
                end
                default: begin
                end
            endcase
        end

        n_wcnt = wcnt_c;
        // fetched byte joins the window below the unread bits
        if (r_rd_vld && !is_clear) begin
            n_win  = {r_win[WIN-9:0], r_rd_data};
            n_wcnt = wcnt_c + WCNT_W'(8);
        end

        if (load_ok) begin
            n_wptr = (r_wptr == AW'(FIFO_DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        end
        if (issue) begin
            n_rptr = (r_rptr == AW'(FIFO_DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        end
        n_mcnt = r_mcnt + CNT_W'(load_ok) - CNT_W'(issue);

        if (is_clear) begin
            n_wptr   = '0;
            n_rptr   = '0;
            n_mcnt   = '0;
            n_rd_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_ok) begin
            r_mem[r_wptr] <= i_cmd.data;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_rptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_mcnt   <= '0;
            r_wcnt   <= '0;
            r_total  <= '0;
            r_pos    <= '0;
            r_o_vld  <= 1'b0;
        end else begin
            r_rd_vld <= n_rd_vld;
            r_wptr   <= n_wptr;
            r_rptr   <= n_rptr;
            r_mcnt   <= n_mcnt;
            r_wcnt   <= n_wcnt;
            r_total  <= n_total;
            r_pos    <= n_pos;
            if (exec) begin
                r_o_vld <= 1'b1;
            end else if (i_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (exec) begin
            r_bits    <= n_bits;
            r_status  <= n_status;
            r_aligned <= n_aligned;
            r_remain  <= mbr_pkg::REMAIN_W'(n_total);
        end
    end

    assign o_valid         = r_o_vld;
    assign o_bits_out      = r_bits;
    assign o_status        = r_status;
    assign o_aligned_count = r_aligned;
    assign o_remain_bits   = r_remain;
    assign o_bit_position  = r_pos;

endmodule
`default_nettype wire

// File: verif/msb_first_bit_reader_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msb_first_bit_reader_tb
// Self-checking testbench for the msb-first bit reader.
// ----------------------------------------------------------------------------
// A queue-fed driver offers words and a monitor keeps a bit-exact model of
// the byte store, the partial byte and the bit counter. Each result word is
// checked field by field. A directed part covers empty reads, zero and
// oversized counts, align, clear, spare codes and loads into a full store.
// Random phases then run with no idling, a slow sender, a slow receiver,
// light idling on both sides, and one long receiver hold-off that backs the
// block up.
// ----------------------------------------------------------------------------
module msb_first_bit_reader_tb;

    localparam int FIFO_DEPTH  = mbr_pkg::DEF_FIFO_DEPTH;
    localparam int MAX_READ    = mbr_pkg::DEF_MAX_READ_BITS;
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int NB_MAX      = (1 << mbr_pkg::NBITS_W) - 1;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 20;
    localparam int CYCLE_LIMIT = 300_000;

    // codes the block does not decode
    localparam logic [mbr_pkg::FUNC_W-1:0] FUNC_SPARE_LO = mbr_pkg::FUNC_CLEAR + 1'b1;
    localparam logic [mbr_pkg::FUNC_W-1:0] FUNC_SPARE_HI = '1;

    typedef struct packed {
        logic [mbr_pkg::FUNC_W-1:0]  func;
        logic [mbr_pkg::NBITS_W-1:0] num_bits;
        logic [mbr_pkg::BYTE_W-1:0]  load_data;
    } t_reader_cmd;

    typedef struct packed {
        logic [mbr_pkg::BITS_W-1:0]   bits_out;
        logic [mbr_pkg::STATUS_W-1:0] status;
        logic [mbr_pkg::ALIGN_W-1:0]  aligned_count;
        logic [mbr_pkg::REMAIN_W-1:0] remain_bits;
        logic [mbr_pkg::POS_W-1:0]    bit_position;
    } t_reader_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_ready;
    logic [mbr_pkg::FUNC_W-1:0]   i_func = '0;
    logic [mbr_pkg::NBITS_W-1:0]  i_num_bits = '0;
    logic [mbr_pkg::BYTE_W-1:0]   i_load_byte = '0;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic [mbr_pkg::BITS_W-1:0]   o_bits_out;
    logic [mbr_pkg::STATUS_W-1:0] o_status;
    logic [mbr_pkg::ALIGN_W-1:0]  o_aligned_count;
    logic [mbr_pkg::REMAIN_W-1:0] o_remain_bits;
    logic [mbr_pkg::POS_W-1:0]    o_bit_position;

    msb_first_bit_reader dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_num_bits      (i_num_bits),
        .i_load_byte     (i_load_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_bits_out      (o_bits_out),
        .o_status        (o_status),
        .o_aligned_count (o_aligned_count),
        .o_remain_bits   (o_remain_bits),
        .o_bit_position  (o_bit_position)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_reader_cmd    pending_words[$];
    t_reader_result predicted_results[$];
    t_reader_cmd    drv_word;
    t_reader_result got_result;
    t_reader_result want_result;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        rx_hold = 1'b0;
    logic        hold_go = 1'b0;
    int          useful_words = 0;
    int          errors = 0;
    int unsigned cycle_count = 0;

    // model of the reader state
    logic [mbr_pkg::BYTE_W-1:0] byte_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]           rd_ptr = '0;
    logic [PTR_W-1:0]           wr_ptr = '0;
    logic [PTR_W:0]             fifo_cnt = '0;
    logic [mbr_pkg::BYTE_W-1:0] part_byte = '0;
    logic [3:0]                 part_left = '0;
    logic [mbr_pkg::POS_W-1:0]  bit_pos = '0;

    function automatic t_reader_result next_reader_result(t_reader_cmd w);
        t_reader_result             r;
        logic [PTR_W-1:0]           rp;
        logic [PTR_W:0]             cnt;
        logic [mbr_pkg::BYTE_W-1:0] pb;
        logic [3:0]                 pl;
        logic                       short_rd;
        r = '0;
        case (w.func)
            mbr_pkg::FUNC_LOAD: begin
                if (fifo_cnt >= FIFO_DEPTH) begin
                    r.status = mbr_pkg::ST_FULL;
                end else begin
                    byte_mem[wr_ptr] = w.load_data;
                    wr_ptr = wr_ptr + 1'b1;
                    fifo_cnt = fifo_cnt + 1'b1;
                end
            end
            mbr_pkg::FUNC_GET, mbr_pkg::FUNC_PEEK: begin
                if (w.num_bits != 0 && w.num_bits <= MAX_READ) begin
                    rp = rd_ptr;
                    cnt = fifo_cnt;
                    pb = part_byte;
                    pl = part_left;
                    short_rd = 1'b0;
                    for (int k = 0; k < w.num_bits; k++) begin
                        // next byte is popped only when a bit is needed
                        if (pl == 0 && cnt != 0) begin
                            pb = byte_mem[rp];
                            rp = rp + 1'b1;
                            cnt = cnt - 1'b1;
                            pl = 4'd8;
                        end
                        if (pl != 0) begin
                            pl = pl - 1'b1;
                            r.bits_out = {r.bits_out[mbr_pkg::BITS_W-2:0], pb[pl[2:0]]};
                        end else begin
                            short_rd = 1'b1;
                            r.bits_out = {r.bits_out[mbr_pkg::BITS_W-2:0], 1'b0};
                        end
                    end
                    r.status = short_rd ? mbr_pkg::ST_SHORT : mbr_pkg::ST_OK;
                    if (w.func == mbr_pkg::FUNC_GET) begin
                        rd_ptr = rp;
                        fifo_cnt = cnt;
                        part_byte = pb;
                        part_left = pl;
                        bit_pos = bit_pos + mbr_pkg::POS_W'(w.num_bits);
                    end
                end
            end
            mbr_pkg::FUNC_ALIGN: begin
                r.aligned_count = part_left[mbr_pkg::ALIGN_W-1:0];
                part_left = '0;
                bit_pos = bit_pos + mbr_pkg::POS_W'(r.aligned_count);
            end
            mbr_pkg::FUNC_CLEAR: begin
                rd_ptr = '0;
                wr_ptr = '0;
                fifo_cnt = '0;
                part_byte = '0;
                part_left = '0;
                bit_pos = '0;
            end
            default: ;
        endcase
        r.remain_bits = mbr_pkg::REMAIN_W'(int'(part_left) + 8 * int'(fifo_cnt));
        r.bit_position = bit_pos;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                drv_word = pending_words.pop_front();
                i_valid     <= 1'b1;
                i_func      <= drv_word.func;
                i_num_bits  <= drv_word.num_bits;
                i_load_byte <= drv_word.load_data;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor: predict on input accept, then check the result word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                predicted_results.push_back(next_reader_result({i_func, i_num_bits,
                                                                i_load_byte}));
            if (o_valid && i_ready) begin
                got_result = {o_bits_out, o_status, o_aligned_count, o_remain_bits,
                              o_bit_position};
                if (predicted_results.size() == 0) begin
                    $error("result word with none pending: bits_out 0x%0h status %0d",
                           o_bits_out, o_status);
                    errors++;
                end else begin
                    want_result = predicted_results.pop_front();
                    check_field("bits_out", want_result.bits_out, got_result.bits_out);
                    check_field("status", 32'(want_result.status),
                                32'(got_result.status));
                    check_field("aligned_count", 32'(want_result.aligned_count),
                                32'(got_result.aligned_count));
                    check_field("remain_bits", 32'(want_result.remain_bits),
                                32'(got_result.remain_bits));
                    check_field("bit_position", want_result.bit_position,
                                got_result.bit_position);
                end
            end
            i_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // long receiver hold-off so the command queue fills and o_ready drops
    initial begin
        wait (hold_go);
        @(negedge i_clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        rx_hold = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [mbr_pkg::NBITS_W-1:0] rand_nb(int unsigned lo,
                                                           int unsigned hi);
        return mbr_pkg::NBITS_W'($urandom_range(lo, hi));
    endfunction

    function automatic logic [mbr_pkg::BYTE_W-1:0] rand_byte();
        return mbr_pkg::BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic queue_word(logic [mbr_pkg::FUNC_W-1:0] fn,
                              logic [mbr_pkg::NBITS_W-1:0] nb,
                              logic [mbr_pkg::BYTE_W-1:0] dat);
        pending_words.push_back(t_reader_cmd'{func: fn, num_bits: nb, load_data: dat});
        if (fn <= mbr_pkg::FUNC_CLEAR &&
            !((fn inside {mbr_pkg::FUNC_GET, mbr_pkg::FUNC_PEEK}) && nb > MAX_READ))
            useful_words++;
    endtask

    task automatic queue_read();
        int sel;
        logic [mbr_pkg::NBITS_W-1:0] nb;
        sel = int'($urandom_range(0, 99));
        nb = ($urandom_range(0, 9) != 0) ? rand_nb(1, MAX_READ) : rand_nb(0, NB_MAX);
        if (sel < 60)
            queue_word(mbr_pkg::FUNC_GET, nb, rand_byte());
        else if (sel < 85)
            queue_word(mbr_pkg::FUNC_PEEK, nb, rand_byte());
        else
            queue_word(mbr_pkg::FUNC_ALIGN, rand_nb(0, NB_MAX), rand_byte());
    endtask

    task automatic queue_segment();
        int sel;
        sel = int'($urandom_range(0, 99));
        if (sel < 1) begin
            // run the store near full, often past it
            repeat ($urandom_range(250, 266))
                queue_word(mbr_pkg::FUNC_LOAD, rand_nb(0, NB_MAX), rand_byte());
            repeat ($urandom_range(8, 24)) queue_read();
        end else if (sel < 72) begin
            repeat ($urandom_range(1, 20))
                queue_word(mbr_pkg::FUNC_LOAD, rand_nb(0, NB_MAX), rand_byte());
            repeat ($urandom_range(1, 16)) queue_read();
        end else if (sel < 74) begin
            queue_word(mbr_pkg::FUNC_CLEAR, rand_nb(0, NB_MAX), rand_byte());
        end else begin
            repeat ($urandom_range(1, 6))
                queue_word(mbr_pkg::FUNC_W'($urandom_range(mbr_pkg::FUNC_LOAD, FUNC_SPARE_HI)),
                           rand_nb(0, NB_MAX), rand_byte());
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || i_valid || predicted_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_random_phase(int tx_pct, int rx_pct, int n_words);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        useful_words = 0;
        while (useful_words < n_words) queue_segment();
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reads of an empty reader, odd counts, spare codes
        queue_word(mbr_pkg::FUNC_GET, 6'd8, 8'h00);
        queue_word(mbr_pkg::FUNC_PEEK, 6'd32, 8'h00);
        queue_word(mbr_pkg::FUNC_GET, 6'd0, 8'h00);
        queue_word(mbr_pkg::FUNC_PEEK, 6'd0, 8'h00);
        queue_word(mbr_pkg::FUNC_GET, 6'd33, 8'h00);
        queue_word(mbr_pkg::FUNC_PEEK, 6'd63, 8'hff);
        queue_word(mbr_pkg::FUNC_ALIGN, 6'd0, 8'h00);
        queue_word(FUNC_SPARE_LO, 6'd63, 8'hff);
        queue_word(FUNC_SPARE_HI, 6'd0, 8'h00);
        // partial bytes, align, read across bytes and past the end
        queue_word(mbr_pkg::FUNC_LOAD, 6'd0, 8'hff);
        queue_word(mbr_pkg::FUNC_LOAD, 6'd63, 8'h00);
        queue_word(mbr_pkg::FUNC_LOAD, 6'd0, 8'ha5);
        queue_word(mbr_pkg::FUNC_LOAD, 6'd0, 8'h5a);
        queue_word(mbr_pkg::FUNC_LOAD, 6'd0, 8'h80);
        queue_word(mbr_pkg::FUNC_PEEK, 6'd12, 8'h00);
        queue_word(mbr_pkg::FUNC_GET, 6'd3, 8'h00);
        queue_word(mbr_pkg::FUNC_ALIGN, 6'd0, 8'h00);
        queue_word(mbr_pkg::FUNC_GET, 6'd1, 8'h00);
        queue_word(mbr_pkg::FUNC_GET, 6'd32, 8'hff);
        queue_word(mbr_pkg::FUNC_ALIGN, 6'd0, 8'h00);
        queue_word(mbr_pkg::FUNC_LOAD, 6'd0, 8'h3c);
        queue_word(mbr_pkg::FUNC_GET, 6'd4, 8'h00);
        queue_word(mbr_pkg::FUNC_CLEAR, 6'd0, 8'h00);
        queue_word(mbr_pkg::FUNC_GET, 6'd8, 8'h00);
        queue_word(FUNC_SPARE_LO + 1'b1, 6'd1, 8'h01);
        wait_drained();

        // fill the store, overflow it, drain a little, refill two slots
        repeat (FIFO_DEPTH + 3) queue_word(mbr_pkg::FUNC_LOAD, 6'd0, rand_byte());
        queue_word(mbr_pkg::FUNC_PEEK, 6'd32, 8'h00);
        queue_word(mbr_pkg::FUNC_GET, 6'd32, 8'h00);
        queue_word(mbr_pkg::FUNC_GET, 6'd32, 8'h00);
        queue_word(mbr_pkg::FUNC_LOAD, 6'd0, 8'hc3);
        queue_word(mbr_pkg::FUNC_LOAD, 6'd0, 8'h7e);
        queue_word(mbr_pkg::FUNC_GET, 6'd17, 8'h00);
        queue_word(mbr_pkg::FUNC_CLEAR, 6'd0, 8'h00);
        wait_drained();

        run_random_phase(0, 0, 250);
        run_random_phase(72, 0, 400);
        run_random_phase(0, 72, 400);
        run_random_phase(6, 6, 400);

        // receiver holds off while the sender keeps offering words
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        useful_words = 0;
        while (useful_words < 100) queue_segment();
        hold_go = 1'b1;
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (errors == 0 && predicted_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
